// ===== rtl/dasp_pkg.sv =====
package dasp_pkg;
  localparam int MOVE_BITS_DEF = 24;
  localparam int POSITION_BITS_DEF = 32;
  localparam int CFG_BITS = 16;
  localparam logic [0:0] CFG_IDX_A = 1'b0;
  localparam logic [0:0] CFG_IDX_B = 1'b1;
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_MOVE = 1'b1;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_take;
    logic tick;
    logic finish_zero;
  } dasp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic busy;
    logic both_zero;
  } dasp_sts_t;
endpackage

// ===== rtl/dual_axis_step_pulse_generator_top.sv =====
// channel | dir | tdata fields (low bit up)                    | tuser
// s_axis  | in  | move_steps_a, move_steps_b, min_a, max_a, min_b, max_b | req_type
// m_axis  | out | step_a, step_b, dir_a, dir_b, busy, position_a, position_b | -
// Tick: one transfer per cycle while the output is free.
// Move: the result waits on the one-bit-a-cycle divider run per axis; a zero count
//   quits its division, two zero counts skip the divider; a busy move loads nothing.
// Reset: synchronous, all control and positions cleared, periods at 1000.
// Output stall holds the result and blocks the next input.
module dual_axis_step_pulse_generator_top #(
  parameter int MOVE_BITS = dasp_pkg::MOVE_BITS_DEF,
  parameter int POSITION_BITS = dasp_pkg::POSITION_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // steps_a, steps_b, min_a, max_a, min_b, max_b, ignored pad
  input  logic [((2*MOVE_BITS+4+7)/8)*8-1:0] s_axis_tdata,
  input  logic s_axis_tuser, // req_type
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // step_a, step_b, dir_a, dir_b, busy, position_a, position_b, zero pad
  output logic [((2*POSITION_BITS+5+7)/8)*8-1:0] m_axis_tdata,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [dasp_pkg::CFG_BITS-1:0] cfg_data
);
  import dasp_pkg::*;
  localparam int OW = ((2*POSITION_BITS+5+7)/8)*8;
  logic [CFG_BITS-1:0] base_a, base_b;
  dasp_cmd_t cmd;
  dasp_sts_t sts;
  logic sa, sb, da, db;
  logic signed [POSITION_BITS-1:0] pa, pb;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_a <= CFG_BITS'(1000); base_b <= CFG_BITS'(1000);
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_A) base_a <= cfg_data;
      else base_b <= cfg_data;
    end
  end

  dasp_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_axis_tvalid), .req(s_axis_tuser), .sts, .cmd,
    .in_ready(s_axis_tready), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready)
  );

  dasp_datapath #(.MOVE_BITS(MOVE_BITS), .POSITION_BITS(POSITION_BITS)) u_dp (
    .clk, .rst, .cmd, .sts, .base_a, .base_b,
    .steps_a(s_axis_tdata[MOVE_BITS-1:0]),
    .steps_b(s_axis_tdata[2*MOVE_BITS-1:MOVE_BITS]),
    .min_a(s_axis_tdata[2*MOVE_BITS]), .max_a(s_axis_tdata[2*MOVE_BITS+1]),
    .min_b(s_axis_tdata[2*MOVE_BITS+2]), .max_b(s_axis_tdata[2*MOVE_BITS+3]),
    .step_a(sa), .step_b(sb), .dir_a(da), .dir_b(db), .pos_a(pa), .pos_b(pb)
  );

  assign m_axis_tdata = OW'({pb, pa, sts.busy, db, da, sb, sa});

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result lost");
  a_noacc: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("overrun");
endmodule

// ===== rtl/dasp_datapath.sv =====
module dasp_datapath #(
  parameter int MOVE_BITS = dasp_pkg::MOVE_BITS_DEF,
  parameter int POSITION_BITS = dasp_pkg::POSITION_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  dasp_pkg::dasp_cmd_t cmd,
  output dasp_pkg::dasp_sts_t sts,
  input  logic [dasp_pkg::CFG_BITS-1:0] base_a,
  input  logic [dasp_pkg::CFG_BITS-1:0] base_b,
  input  logic signed [MOVE_BITS-1:0] steps_a,
  input  logic signed [MOVE_BITS-1:0] steps_b,
  input  logic min_a,
  input  logic max_a,
  input  logic min_b,
  input  logic max_b,
  output logic step_a,
  output logic step_b,
  output logic dir_a,
  output logic dir_b,
  output logic signed [POSITION_BITS-1:0] pos_a,
  output logic signed [POSITION_BITS-1:0] pos_b
);
  import dasp_pkg::*;
  localparam int MB = MOVE_BITS - 1;
  localparam int HB = CFG_BITS + MB + 1;
  localparam int QB = $clog2(HB + 1);

  logic [MB-1:0] rem_a, rem_b, taken_a, taken_b, na, nb;
  logic [HB-1:0] half_a, half_b, cnt_a, cnt_b, longest;
  logic phase_a, phase_b;
  logic [HB-1:0] quo, rmd;
  logic [QB-1:0] bitc;
  logic div_run, div_sel;
  logic zmin_a, zmin_b;

  function automatic logic [MB-1:0] mag(input logic [MOVE_BITS-1:0] v);
    logic [MOVE_BITS-1:0] m;
    m = v[MOVE_BITS-1] ? (~v + 1'b1) : v;
    if (m[MOVE_BITS-1]) return {MB{1'b1}};
    return m[MB-1:0];
  endfunction

  logic [MB-1:0] ma, mb;
  logic [HB-1:0] pa, pb;
  assign ma = mag(steps_a);
  assign mb = mag(steps_b);
  assign pa = HB'(base_a) * HB'(ma);
  assign pb = HB'(base_b) * HB'(mb);

  logic [MB-1:0] dvs;
  logic [HB:0] trial;
  assign dvs = div_sel ? nb : na;
  assign trial = {rmd, longest[bitc - 1'b1]} - (HB + 1)'(dvs);

  assign sts.busy = (rem_a != '0) || (rem_b != '0);
  assign sts.div_done = !div_run;
  assign sts.both_zero = (na == '0) && (nb == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem_a <= '0; rem_b <= '0; taken_a <= '0; taken_b <= '0;
      cnt_a <= '0; cnt_b <= '0; phase_a <= 1'b1; phase_b <= 1'b1;
      dir_a <= 1'b0; dir_b <= 1'b0; pos_a <= '0; pos_b <= '0;
      step_a <= 1'b0; step_b <= 1'b0; div_run <= 1'b0; div_sel <= 1'b0;
      half_a <= '0; half_b <= '0; na <= '0; nb <= '0;
    end else begin
      if (cmd.load) begin
        na <= ma; nb <= mb;
        dir_a <= steps_a[MOVE_BITS-1]; dir_b <= steps_b[MOVE_BITS-1];
        zmin_a <= min_a; zmin_b <= min_b;
        longest <= (pa > pb) ? pa : pb;
        cnt_a <= '0; cnt_b <= '0; phase_a <= 1'b1; phase_b <= 1'b1;
        taken_a <= '0; taken_b <= '0; step_a <= 1'b0; step_b <= 1'b0;
        half_a <= '0; half_b <= '0; div_sel <= 1'b0;
      end
      if (cmd.div_start) begin
        div_run <= 1'b1; bitc <= QB'(HB); quo <= '0; rmd <= '0;
      end else if (div_run) begin
        if (dvs == '0) begin
          div_run <= 1'b0;
        end else if (bitc == '0) begin
          if (div_sel) half_b <= quo;
          else half_a <= quo;
          div_run <= 1'b0;
        end else begin
          bitc <= bitc - 1'b1;
          if (!trial[HB]) begin
            rmd <= trial[HB-1:0]; quo <= {quo[HB-2:0], 1'b1};
          end else begin
            rmd <= {rmd[HB-2:0], longest[bitc - 1'b1]}; quo <= {quo[HB-2:0], 1'b0};
          end
        end
      end
      if (cmd.div_take) begin
        if (!div_sel) div_sel <= 1'b1;
        else begin
          rem_a <= na; rem_b <= nb;
        end
      end
      if (cmd.finish_zero) begin
        if (zmin_a) pos_a <= '0;
        if (zmin_b) pos_b <= '0;
      end
      if (cmd.tick) begin : tk
        logic [MB-1:0] ra, rb, ta, tb;
        logic ok_a, ok_b;
        ra = rem_a; rb = rem_b; ta = taken_a; tb = taken_b;
        ok_a = !(dir_a ? min_a : max_a);
        ok_b = !(dir_b ? min_b : max_b);
        if (rem_a != '0) begin
          if (cnt_a + 1'b1 <= half_a) cnt_a <= cnt_a + 1'b1;
          else begin
            cnt_a <= '0; step_a <= phase_a && ok_a; phase_a <= !phase_a;
            if (!phase_a) begin
              ra = ra - 1'b1;
              if (ok_a) ta = ta + 1'b1;
            end
          end
        end
        if (rem_b != '0) begin
          if (cnt_b + 1'b1 <= half_b) cnt_b <= cnt_b + 1'b1;
          else begin
            cnt_b <= '0; step_b <= phase_b && ok_b; phase_b <= !phase_b;
            if (!phase_b) begin
              rb = rb - 1'b1;
              if (ok_b) tb = tb + 1'b1;
            end
          end
        end
        if (ra == '0 && rb == '0) begin
          pos_a <= min_a ? '0 : (dir_a ? pos_a - POSITION_BITS'(ta) : pos_a + POSITION_BITS'(ta));
          pos_b <= min_b ? '0 : (dir_b ? pos_b - POSITION_BITS'(tb) : pos_b + POSITION_BITS'(tb));
          ta = '0; tb = '0;
        end
        rem_a <= ra; rem_b <= rb; taken_a <= ta; taken_b <= tb;
      end
    end
  end
endmodule

// ===== rtl/dasp_ctrl.sv =====
module dasp_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic req,
  input  dasp_pkg::dasp_sts_t sts,
  output dasp_pkg::dasp_cmd_t cmd,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready
);
  import dasp_pkg::*;
  localparam logic [1:0] S_RUN = 2'd0;
  localparam logic [1:0] S_DIV = 2'd1;
  localparam logic [1:0] S_DIV2 = 2'd2;

  logic [1:0] state, state_next;
  logic ov_next, acc;
  logic second, second_next;

  assign in_ready = (state == S_RUN) && (!out_valid || out_ready);
  assign acc = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    state_next = state;
    second_next = second;
    ov_next = out_valid && !out_ready;
    unique case (state)
      S_RUN: begin
        if (acc) begin
          if (req == REQ_MOVE) begin
            if (sts.busy) ov_next = 1'b1;
            else begin
              cmd.load = 1'b1;
              state_next = S_DIV;
            end
          end else begin
            cmd.tick = sts.busy;
            ov_next = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (sts.both_zero) begin
          cmd.finish_zero = 1'b1;
          ov_next = 1'b1;
          state_next = S_RUN;
        end else begin
          cmd.div_start = 1'b1;
          state_next = S_DIV2;
        end
      end
      S_DIV2: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          if (second) begin
            second_next = 1'b0;
            ov_next = 1'b1;
            state_next = S_RUN;
          end else begin
            second_next = 1'b1;
            state_next = S_DIV;
          end
        end
      end
      default: begin
        state_next = S_RUN;
        second_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN; out_valid <= 1'b0; second <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= ov_next;
      second <= second_next;
    end
  end
endmodule
